[rtl/core/cpu_exception_priority_unit_assert.svh]
// ----------------------------------------------------------------------------
// Exception priority unit assertion macros
// Concurrent check wrappers; compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef CPU_EXCEPTION_PRIORITY_UNIT_ASSERT_SVH
`define CPU_EXCEPTION_PRIORITY_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define CPEPU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CPEPU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CPEPU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define CPEPU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[rtl/core/cpepu_pkg.sv]
// ----------------------------------------------------------------------------
// Exception priority unit package
// Item types, exception and cause codes, priority and vector functions.
// ----------------------------------------------------------------------------
`default_nettype none

package cpepu_pkg;

    localparam logic ACT_SIGNAL = 1'b0;
    localparam logic ACT_HANDLE = 1'b1;

    localparam logic [4:0] K_ADDR   = 5'd0;
    localparam logic [4:0] K_BRK    = 5'd1;
    localparam logic [4:0] K_BUS    = 5'd2;
    localparam logic [4:0] K_COLD   = 5'd3;
    localparam logic [4:0] K_COPU   = 5'd4;
    localparam logic [4:0] K_FP     = 5'd5;
    localparam logic [4:0] K_OVF    = 5'd6;
    localparam logic [4:0] K_INT    = 5'd7;
    localparam logic [4:0] K_NMI    = 5'd8;
    localparam logic [4:0] K_RI     = 5'd9;
    localparam logic [4:0] K_SOFT   = 5'd10;
    localparam logic [4:0] K_SYS    = 5'd11;
    localparam logic [4:0] K_TLBI   = 5'd12;
    localparam logic [4:0] K_TLBM   = 5'd13;
    localparam logic [4:0] K_TLBMOD = 5'd14;
    localparam logic [4:0] K_TRAP   = 5'd15;
    localparam logic [4:0] K_WATCH  = 5'd16;
    localparam logic [4:0] K_XTLB   = 5'd17;

    localparam logic [1:0] ACC_READ  = 2'd0;
    localparam logic [1:0] ACC_WRITE = 2'd1;
    localparam logic [1:0] ACC_FETCH = 2'd2;
    localparam logic [1:0] ACC_RESV  = 2'd3;

    localparam logic [4:0] EXC_INT   = 5'd0;
    localparam logic [4:0] EXC_MOD   = 5'd1;
    localparam logic [4:0] EXC_TLBL  = 5'd2;
    localparam logic [4:0] EXC_TLBS  = 5'd3;
    localparam logic [4:0] EXC_ADEL  = 5'd4;
    localparam logic [4:0] EXC_ADES  = 5'd5;
    localparam logic [4:0] EXC_IBE   = 5'd6;
    localparam logic [4:0] EXC_DBE   = 5'd7;
    localparam logic [4:0] EXC_SYS   = 5'd8;
    localparam logic [4:0] EXC_BP    = 5'd9;
    localparam logic [4:0] EXC_RI    = 5'd10;
    localparam logic [4:0] EXC_CPU   = 5'd11;
    localparam logic [4:0] EXC_OV    = 5'd12;
    localparam logic [4:0] EXC_TR    = 5'd13;
    localparam logic [4:0] EXC_FPE   = 5'd15;
    localparam logic [4:0] EXC_WATCH = 5'd23;

    localparam int ST_EXL = 0;
    localparam int ST_ERL = 1;
    localparam int ST_BEV = 2;
    localparam int ST_SR  = 3;
    localparam int ST_TS  = 4;
    localparam int ST_RP  = 5;

    localparam logic [63:0] VEC_BASE_NORMAL = 64'hFFFF_FFFF_8000_0000;
    localparam logic [63:0] VEC_BASE_BOOT   = 64'hFFFF_FFFF_BFC0_0200;
    localparam logic [63:0] VEC_GENERAL     = 64'h0000_0000_0000_0180;
    localparam logic [63:0] VEC_XTLB_REFILL = 64'h0000_0000_0000_0080;

    localparam logic [4:0] PRIO_PLAIN [18] = '{
        5'd6, 5'd12, 5'd1, 5'd20, 5'd11, 5'd7, 5'd8, 5'd0, 5'd18,
        5'd10, 5'd19, 5'd13, 5'd4, 5'd5, 5'd3, 5'd9, 5'd2, 5'd5
    };

    typedef struct packed {
        logic        action;
        logic [4:0]  exception_kind;
        logic [1:0]  access_kind;
        logic [63:0] bad_address;
        logic [4:0]  page_offset_bits;
        logic [7:0]  current_asid;
        logic [1:0]  cop_unit;
        logic [63:0] current_pc;
        logic        in_delay_slot;
        logic [63:0] error_return_pc;
    } t_in_item;

    typedef struct packed {
        logic        handled;
        logic [63:0] next_pc;
        logic [63:0] return_pc;
        logic [4:0]  cause_code;
        logic [1:0]  cause_cop;
        logic        cause_delay;
        logic [5:0]  status_flags;
        logic [63:0] bad_vaddr_reg;
        logic [39:0] context_vpn;
        logic [39:0] xcontext_vpn;
        logic [39:0] entry_vpn;
        logic [7:0]  entry_asid;
    } t_out_item;

    function automatic logic [4:0] priority_of(input logic [4:0] kind, input logic [1:0] acc);
        logic [4:0] p;
        p = 5'd0;
        if (kind <= K_XTLB) begin
            p = PRIO_PLAIN[kind];
        end
        if (acc == ACC_FETCH) begin
            if (kind == K_ADDR) begin
                p = 5'd17;
            end else if (kind == K_BUS) begin
                p = 5'd14;
            end else if (kind == K_TLBI) begin
                p = 5'd15;
            end else if (kind == K_TLBM || kind == K_XTLB) begin
                p = 5'd16;
            end
        end
        return p;
    endfunction

    function automatic logic [63:0] vector_of(input logic [4:0] kind, input logic bev,
                                              input logic exl);
        logic [63:0] base;
        logic [63:0] v;
        base = bev ? VEC_BASE_BOOT : VEC_BASE_NORMAL;
        if (kind == K_COLD || kind == K_SOFT || kind == K_NMI) begin
            v = VEC_BASE_BOOT;
        end else if (kind == K_TLBM) begin
            v = exl ? (base | VEC_GENERAL) : base;
        end else if (kind == K_XTLB) begin
            v = base | (exl ? VEC_GENERAL : VEC_XTLB_REFILL);
        end else begin
            v = base | VEC_GENERAL;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

[rtl/core/cpepu_in_if.sv]
// ----------------------------------------------------------------------------
// Exception priority unit event channel
// Valid/ready channel carrying one exception event per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface cpepu_in_if;
    import cpepu_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/cpepu_out_if.sv]
// ----------------------------------------------------------------------------
// Exception priority unit result channel
// Valid/ready channel carrying one register view per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface cpepu_out_if;
    import cpepu_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/cpu_exception_priority_unit.sv]
// ----------------------------------------------------------------------------
// CPU exception priority unit
// Latches the highest-priority signaled exception and dispatches it on a
// handle event, updating cause, EPC, status and fault address registers.
// ----------------------------------------------------------------------------
//  channel  dir  modport  payload
//  i_in     in   sink     action, kind, access, address, pc, ... (t_in_item)
//  o_out    out  source   handled, next_pc, register view (t_out_item)
//
//  One transfer per cycle sustained while o_out is ready; each item passes
//  through the input register, then the result register.
//  Sync reset clears pending state, all CP0 registers and both valid bits.
//  A stall on o_out holds the result; the input register accepts one more
//  transfer only if it is empty, and i_in.ready is low while it is full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cpu_exception_priority_unit_assert.svh"

module cpu_exception_priority_unit (
    input  wire          i_clk,
    input  wire          i_rst_n,
    cpepu_in_if.sink     i_in,
    cpepu_out_if.source  o_out
);
    import cpepu_pkg::*;

    logic      r_in_vld;
    t_in_item  r_in;
    logic      r_out_vld;
    t_out_item r_out;
    t_out_item n_out;
    logic      w_adv;

    logic        r_pend,     n_pend;
    logic [4:0]  r_pend_prio, n_pend_prio;
    logic [4:0]  r_pend_kind, n_pend_kind;
    logic [1:0]  r_pend_acc, n_pend_acc;
    logic [63:0] r_pend_vec, n_pend_vec;
    logic [63:0] r_sv_addr,  n_sv_addr;
    logic [39:0] r_sv_vpn,   n_sv_vpn;
    logic [7:0]  r_sv_asid,  n_sv_asid;
    logic [5:0]  r_status,   n_status;
    logic [63:0] r_epc,      n_epc;
    logic [7:0]  r_cause,    n_cause;
    logic [63:0] r_bvaddr,   n_bvaddr;
    logic [39:0] r_ctx,      n_ctx;
    logic [39:0] r_xctx,     n_xctx;
    logic [39:0] r_ehi_vpn,  n_ehi_vpn;
    logic [7:0]  r_ehi_asid, n_ehi_asid;

    assign w_adv      = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || w_adv;
    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

    always_comb begin
        logic [1:0]  acc;
        logic [4:0]  prio;
        logic        take;
        logic        fault;
        logic [5:0]  sh;
        logic [63:0] shifted;
        logic        wr;
        logic [63:0] npc;
        logic        hnd;

        n_pend      = r_pend;
        n_pend_prio = r_pend_prio;
        n_pend_kind = r_pend_kind;
        n_pend_acc  = r_pend_acc;
        n_pend_vec  = r_pend_vec;
        n_sv_addr   = r_sv_addr;
        n_sv_vpn    = r_sv_vpn;
        n_sv_asid   = r_sv_asid;
        n_status    = r_status;
        n_epc       = r_epc;
        n_cause     = r_cause;
        n_bvaddr    = r_bvaddr;
        n_ctx       = r_ctx;
        n_xctx      = r_xctx;
        n_ehi_vpn   = r_ehi_vpn;
        n_ehi_asid  = r_ehi_asid;

        acc  = (r_in.access_kind == ACC_RESV) ? ACC_READ : r_in.access_kind;
        prio = priority_of(r_in.exception_kind, acc);
        take = (r_in.action == ACT_SIGNAL) && (r_in.exception_kind <= K_XTLB)
               && (!r_pend || prio >= r_pend_prio);
        fault = (r_in.exception_kind == K_ADDR) || (r_in.exception_kind == K_TLBI)
                || (r_in.exception_kind == K_TLBM) || (r_in.exception_kind == K_TLBMOD)
                || (r_in.exception_kind == K_XTLB);
        sh      = {1'b0, r_in.page_offset_bits} + 6'd1;
        shifted = r_in.bad_address >> sh;
        wr      = (r_pend_acc == ACC_WRITE);
        hnd     = (r_in.action == ACT_HANDLE) && r_pend;
        npc     = 64'd0;

        if (take) begin
            n_pend      = 1'b1;
            n_pend_prio = prio;
            n_pend_kind = r_in.exception_kind;
            n_pend_acc  = acc;
            n_pend_vec  = vector_of(r_in.exception_kind, r_status[ST_BEV], r_status[ST_EXL]);
            if (fault) begin
                n_sv_addr = r_in.bad_address;
                n_sv_vpn  = shifted[39:0];
                n_sv_asid = r_in.current_asid;
            end
        end

        if (hnd) begin
            n_pend     = 1'b0;
            n_cause[7] = r_in.in_delay_slot;
            if (!r_status[ST_EXL]) begin
                n_epc            = r_in.current_pc - (r_in.in_delay_slot ? 64'd8 : 64'd4);
                n_status[ST_EXL] = 1'b1;
            end
            npc = r_pend_vec;
            case (r_pend_kind)
                K_ADDR: begin
                    n_cause[6:0] = {2'd0, wr ? EXC_ADES : EXC_ADEL};
                    n_bvaddr     = r_sv_addr;
                    n_ctx        = r_sv_vpn;
                end
                K_BRK: begin
                    n_cause[4:0] = EXC_BP;
                end
                K_BUS: begin
                    n_cause[6:0] = {2'd0, (r_pend_acc == ACC_FETCH) ? EXC_IBE : EXC_DBE};
                end
                K_COLD: begin
                    n_status[ST_RP]  = 1'b0;
                    n_status[ST_SR]  = 1'b0;
                    n_status[ST_TS]  = 1'b0;
                    n_status[ST_ERL] = 1'b1;
                    n_status[ST_BEV] = 1'b1;
                end
                K_COPU: begin
                    n_cause[6:0] = {r_in.cop_unit, EXC_CPU};
                end
                K_FP: begin
                    n_cause[6:0] = {2'd0, EXC_FPE};
                end
                K_OVF: begin
                    n_cause[6:0] = {2'd0, EXC_OV};
                end
                K_INT: begin
                    n_cause[6:0] = {2'd0, EXC_INT};
                end
                K_NMI: begin
                    npc              = r_in.error_return_pc;
                    n_status[ST_TS]  = 1'b0;
                    n_status[ST_ERL] = 1'b1;
                    n_status[ST_SR]  = 1'b1;
                    n_status[ST_BEV] = 1'b1;
                    n_cause[6:5]     = 2'd0;
                end
                K_RI: begin
                    n_cause[6:0] = {2'd0, EXC_RI};
                end
                K_SOFT: begin
                    if (!r_status[ST_ERL]) begin
                        npc = r_in.error_return_pc;
                    end
                    n_status[ST_RP]  = 1'b0;
                    n_status[ST_TS]  = 1'b0;
                    n_status[ST_BEV] = 1'b1;
                    n_status[ST_ERL] = 1'b1;
                    n_status[ST_SR]  = 1'b1;
                end
                K_SYS: begin
                    n_cause[6:0] = {2'd0, EXC_SYS};
                end
                K_TLBI, K_TLBM: begin
                    n_cause[6:0] = {2'd0, wr ? EXC_TLBS : EXC_TLBL};
                    n_bvaddr     = r_sv_addr;
                    n_ctx        = r_sv_vpn;
                    n_ehi_vpn    = r_sv_vpn;
                    n_ehi_asid   = r_sv_asid;
                end
                K_TLBMOD: begin
                    n_cause[6:0] = {2'd0, EXC_MOD};
                    n_bvaddr     = r_sv_addr;
                    n_ctx        = r_sv_vpn;
                    n_ehi_vpn    = r_sv_vpn;
                    n_ehi_asid   = r_sv_asid;
                end
                K_TRAP: begin
                    n_cause[6:0] = {2'd0, EXC_TR};
                end
                K_WATCH: begin
                    n_cause[6:0] = {2'd0, EXC_WATCH};
                end
                default: begin
                    n_cause[6:0] = {2'd0, wr ? EXC_TLBS : EXC_TLBL};
                    n_bvaddr     = r_sv_addr;
                    n_ctx        = r_sv_vpn;
                    n_xctx       = r_sv_vpn;
                    n_ehi_vpn    = r_sv_vpn;
                    n_ehi_asid   = r_sv_asid;
                end
            endcase
        end

        n_out.handled       = hnd;
        n_out.next_pc       = npc;
        n_out.return_pc     = n_epc;
        n_out.cause_code    = n_cause[4:0];
        n_out.cause_cop     = n_cause[6:5];
        n_out.cause_delay   = n_cause[7];
        n_out.status_flags  = n_status;
        n_out.bad_vaddr_reg = n_bvaddr;
        n_out.context_vpn   = n_ctx;
        n_out.xcontext_vpn  = n_xctx;
        n_out.entry_vpn     = n_ehi_vpn;
        n_out.entry_asid    = n_ehi_asid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
            r_pend      <= 1'b0;
            r_pend_prio <= '0;
            r_pend_kind <= '0;
            r_pend_acc  <= '0;
            r_pend_vec  <= '0;
            r_sv_addr   <= '0;
            r_sv_vpn    <= '0;
            r_sv_asid   <= '0;
            r_status    <= '0;
            r_epc       <= '0;
            r_cause     <= '0;
            r_bvaddr    <= '0;
            r_ctx       <= '0;
            r_xctx      <= '0;
            r_ehi_vpn   <= '0;
            r_ehi_asid  <= '0;
        end else begin
            if (i_in.ready) begin
                r_in_vld <= i_in.valid;
            end
            if (w_adv) begin
                r_out_vld   <= 1'b1;
                r_pend      <= n_pend;
                r_pend_prio <= n_pend_prio;
                r_pend_kind <= n_pend_kind;
                r_pend_acc  <= n_pend_acc;
                r_pend_vec  <= n_pend_vec;
                r_sv_addr   <= n_sv_addr;
                r_sv_vpn    <= n_sv_vpn;
                r_sv_asid   <= n_sv_asid;
                r_status    <= n_status;
                r_epc       <= n_epc;
                r_cause     <= n_cause;
                r_bvaddr    <= n_bvaddr;
                r_ctx       <= n_ctx;
                r_xctx      <= n_xctx;
                r_ehi_vpn   <= n_ehi_vpn;
                r_ehi_asid  <= n_ehi_asid;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in <= i_in.data;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    `CPEPU_ASSERT_NOW(a_handled_sets_exl, i_clk, i_rst_n, r_out_vld && r_out.handled, r_out.status_flags[ST_EXL], "handled result without EXL set")
    `CPEPU_ASSERT_NEXT(a_handle_clears_pending, i_clk, i_rst_n, w_adv && (r_in.action == ACT_HANDLE), !r_pend, "pending exception survived a handle event")
    `CPEPU_ASSERT_NEXT(a_signal_sets_pending, i_clk, i_rst_n, w_adv && (r_in.action == ACT_SIGNAL) && (r_in.exception_kind <= K_XTLB) && !r_pend, r_pend, "valid signal with nothing pending was not latched")

endmodule

`default_nettype wire
